FILE: src/nlls_pkg.sv
// shared types, constants and codes of the nearest lane line selector
package nlls_pkg;

  localparam int COORD_BITS       = 12;
  localparam int CFG_W            = 12;
  localparam int HOLD_W           = 8;
  localparam int INDEX_W          = 8;
  localparam int CFG_INDEX_W      = 3;
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int NUM_W     = 2 * DIFF_W;
  localparam int MAG_W     = NUM_W - 1;
  localparam int QUO_W     = 2 * ((MAG_W + 1) / 2);
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int REM_W     = COORD_BITS + 1;
  localparam int OFF_W     = QUO_W + 2;

  localparam logic [CFG_W-1:0]  CENTER_COLUMN_RST    = CFG_W'(930);
  localparam logic [CFG_W-1:0]  SCAN_ROW_RST         = CFG_W'(710);
  localparam logic [CFG_W-1:0]  SEARCH_LIMIT_RST     = CFG_W'(500);
  localparam logic [CFG_W-1:0]  FAR_LEFT_LIMIT_RST   = CFG_W'(180);
  localparam logic [CFG_W-1:0]  NEAR_RIGHT_LIMIT_RST = CFG_W'(90);
  localparam logic [CFG_W-1:0]  NEAR_LEFT_LIMIT_RST  = CFG_W'(60);
  localparam logic [CFG_W-1:0]  FAR_RIGHT_LIMIT_RST  = CFG_W'(190);
  localparam logic [HOLD_W-1:0] WARNING_HOLD_RST     = HOLD_W'(25);

  localparam logic REQ_SEGMENT   = 1'b0;
  localparam logic REQ_FRAME_END = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_COLUMN    = 3'd0,
    REG_SCAN_ROW         = 3'd1,
    REG_SEARCH_LIMIT     = 3'd2,
    REG_FAR_LEFT_LIMIT   = 3'd3,
    REG_NEAR_RIGHT_LIMIT = 3'd4,
    REG_NEAR_LEFT_LIMIT  = 3'd5,
    REG_FAR_RIGHT_LIMIT  = 3'd6,
    REG_WARNING_HOLD     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  center_column;
    logic [CFG_W-1:0]  scan_row;
    logic [CFG_W-1:0]  search_limit;
    logic [CFG_W-1:0]  far_left_limit;
    logic [CFG_W-1:0]  near_right_limit;
    logic [CFG_W-1:0]  near_left_limit;
    logic [CFG_W-1:0]  far_right_limit;
    logic [HOLD_W-1:0] warning_hold;
  } cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] seg_x1;
    logic [COORD_BITS-1:0] seg_y1;
    logic [COORD_BITS-1:0] seg_x2;
    logic [COORD_BITS-1:0] seg_y2;
  } in_word_t;

  typedef struct packed {
    logic               left_found;
    logic               right_found;
    logic [CFG_W-1:0]   left_distance;
    logic [CFG_W-1:0]   right_distance;
    logic [INDEX_W-1:0] left_segment;
    logic [INDEX_W-1:0] right_segment;
    logic               warn_change_right;
    logic               warn_change_left;
  } out_word_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic                  is_eof;
    logic                  neg_quo;
    logic                  slope_pos;
    logic [MAG_W-1:0]      num_mag;
    logic [COORD_BITS-1:0] dy_mag;
    logic [INDEX_W-1:0]    idx;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPDATE
  } back_state_t;

endpackage

FILE: src/nlls_front.sv
// front end: accepts words, numbers segments, passes on only steep ones and forms the crossing numerator
module nlls_front import nlls_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  input  logic [CFG_W-1:0] scan_row,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  accept, is_frame, room, steep;
  logic signed [DIFF_W-1:0] dx, dy, row_d;
  logic [COORD_BITS-1:0] adx, ady;
  logic [COORD_BITS+2:0] ady5, adx2;
  logic signed [NUM_W-1:0]  p1, p2, num, num_abs;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_frame = (in_word.req_type == REQ_FRAME_END);
  assign room     = (count_r != CNT_W'(MAX_SEGMENTS));

  always_comb begin
    dx    = $signed({1'b0, in_word.seg_x2}) - $signed({1'b0, in_word.seg_x1});
    dy    = $signed({1'b0, in_word.seg_y2}) - $signed({1'b0, in_word.seg_y1});
    row_d = $signed({1'b0, scan_row}) - $signed({1'b0, in_word.seg_y2});
    adx   = dx[DIFF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady   = dy[DIFF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    ady5  = ({3'b000, ady} << 2) + {3'b000, ady};
    adx2  = {3'b000, adx} << 1;
    steep = (ady5 > adx2);
    p1    = NUM_W'($signed({1'b0, in_word.seg_x2})) * NUM_W'(dy);
    p2    = NUM_W'(row_d) * NUM_W'(dx);
    num   = p1 + p2;
    num_abs = num[NUM_W-1] ? -num : num;

    q_job.is_eof    = is_frame;
    q_job.neg_quo   = num[NUM_W-1] ^ dy[DIFF_W-1];
    q_job.slope_pos = (dx[DIFF_W-1] == dy[DIFF_W-1]);
    q_job.num_mag   = num_abs[MAG_W-1:0];
    q_job.dy_mag    = ady;
    q_job.idx       = INDEX_W'(count_r);

    q_push = accept && (is_frame || (room && steep));

    count_nxt = count_r;
    if (accept) begin
      if (is_frame) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/nlls_queue.sv
// short first-in first-out queue of classified words between front and back
module nlls_queue import nlls_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t job_out
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign job_out = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

FILE: src/nlls_back.sv
// back end: radix-4 divider for the crossing, nearest-side tracking and frame-end report
module nlls_back import nlls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  back_state_t           state_r, state_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [COORD_BITS-1:0] div_r, div_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  neg_r, neg_nxt, slope_r, slope_nxt;
  logic [INDEX_W-1:0]    idx_r, idx_nxt;

  logic [CFG_W-1:0]   best_left_r, best_left_nxt, best_right_r, best_right_nxt;
  logic [INDEX_W-1:0] left_idx_r, left_idx_nxt, right_idx_r, right_idx_nxt;
  logic               left_seen_r, left_seen_nxt, right_seen_r, right_seen_nxt;
  logic [HOLD_W-1:0]  hold_right_r, hold_right_nxt, hold_left_r, hold_left_nxt;
  logic [HOLD_W-1:0]  hold_right_new, hold_left_new;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic [REM_W+QUO_W-1:0]   stage1, stage2;
  logic signed [OFF_W-1:0]  quo_s, crossing, offset;
  logic [OFF_W-1:0]         off_abs;
  logic                     off_neg, off_zero, out_free, both_seen;

  function automatic logic [REM_W+QUO_W-1:0] div_step(
    input logic [REM_W-1:0]      rem,
    input logic [QUO_W-1:0]      quo,
    input logic [COORD_BITS-1:0] d
  );
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_o;
    logic             bit_o;
    trial = {rem[REM_W-2:0], quo[QUO_W-1]};
    if (trial >= {1'b0, d}) begin
      rem_o = trial - {1'b0, d};
      bit_o = 1'b1;
    end else begin
      rem_o = trial;
      bit_o = 1'b0;
    end
    return {rem_o, quo[QUO_W-2:0], bit_o};
  endfunction

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign both_seen = left_seen_r && right_seen_r;

  always_comb begin
    stage1 = div_step(rem_r, quo_r, div_r);
    stage2 = div_step(stage1[REM_W+QUO_W-1:QUO_W], stage1[QUO_W-1:0], div_r);

    quo_s    = $signed({2'b00, quo_r});
    crossing = neg_r ? -quo_s : quo_s;
    offset   = crossing - $signed(OFF_W'(cfg.center_column));
    off_neg  = offset[OFF_W-1];
    off_abs  = off_neg ? OFF_W'(-offset) : OFF_W'(offset);
    off_zero = (offset == '0);

    hold_right_new = hold_right_r;
    hold_left_new  = hold_left_r;
    if (both_seen && best_left_r > cfg.far_left_limit &&
        best_right_r < cfg.near_right_limit) begin
      hold_right_new = cfg.warning_hold;
    end
    if (both_seen && best_left_r < cfg.near_left_limit &&
        best_right_r > cfg.far_right_limit) begin
      hold_left_new = cfg.warning_hold;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    step_nxt       = step_r;
    neg_nxt        = neg_r;
    slope_nxt      = slope_r;
    idx_nxt        = idx_r;
    best_left_nxt  = best_left_r;
    best_right_nxt = best_right_r;
    left_idx_nxt   = left_idx_r;
    right_idx_nxt  = right_idx_r;
    left_seen_nxt  = left_seen_r;
    right_seen_nxt = right_seen_r;
    hold_right_nxt = hold_right_r;
    hold_left_nxt  = hold_left_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    q_pop          = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && q_job.is_eof) begin
          if (out_free) begin
            q_pop                          = 1'b1;
            out_valid_nxt                  = 1'b1;
            out_word_nxt.left_found        = left_seen_r;
            out_word_nxt.right_found       = right_seen_r;
            out_word_nxt.left_distance     = best_left_r;
            out_word_nxt.right_distance    = best_right_r;
            out_word_nxt.left_segment      = left_idx_r;
            out_word_nxt.right_segment     = right_idx_r;
            out_word_nxt.warn_change_right = (hold_right_new != '0);
            out_word_nxt.warn_change_left  = (hold_left_new != '0);
            hold_right_nxt = (hold_right_new != '0) ? hold_right_new - HOLD_W'(1) : '0;
            hold_left_nxt  = (hold_left_new != '0) ? hold_left_new - HOLD_W'(1) : '0;
            // new frame
            best_left_nxt  = cfg.search_limit;
            best_right_nxt = cfg.search_limit;
            left_idx_nxt   = '0;
            right_idx_nxt  = '0;
            left_seen_nxt  = 1'b0;
            right_seen_nxt = 1'b0;
          end
        end else if (q_valid) begin
          q_pop     = 1'b1;
          rem_nxt   = '0;
          quo_nxt   = QUO_W'(q_job.num_mag);
          div_nxt   = q_job.dy_mag;
          step_nxt  = '0;
          neg_nxt   = q_job.neg_quo;
          slope_nxt = q_job.slope_pos;
          idx_nxt   = q_job.idx;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt  = stage2[REM_W+QUO_W-1:QUO_W];
        quo_nxt  = stage2[QUO_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (!off_neg && !off_zero && slope_r && off_abs < OFF_W'(best_right_r)) begin
          best_right_nxt = off_abs[CFG_W-1:0];
          right_idx_nxt  = idx_r;
          right_seen_nxt = 1'b1;
        end
        if (off_neg && !slope_r && off_abs < OFF_W'(best_left_r)) begin
          best_left_nxt = off_abs[CFG_W-1:0];
          left_idx_nxt  = idx_r;
          left_seen_nxt = 1'b1;
        end
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      best_left_r  <= SEARCH_LIMIT_RST;
      best_right_r <= SEARCH_LIMIT_RST;
      left_idx_r   <= '0;
      right_idx_r  <= '0;
      left_seen_r  <= 1'b0;
      right_seen_r <= 1'b0;
      hold_right_r <= '0;
      hold_left_r  <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      best_left_r  <= best_left_nxt;
      best_right_r <= best_right_nxt;
      left_idx_r   <= left_idx_nxt;
      right_idx_r  <= right_idx_nxt;
      left_seen_r  <= left_seen_nxt;
      right_seen_r <= right_seen_nxt;
      hold_right_r <= hold_right_nxt;
      hold_left_r  <= hold_left_nxt;
      out_valid_r  <= out_valid_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_r      <= div_nxt;
    neg_r      <= neg_nxt;
    slope_r    <= slope_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

FILE: src/nearest_lane_line_selector_top.sv
// top level of the nearest lane line selector: configuration registers and front/queue/back
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  in_word_t: request type and segment end points
//   out_     output     out_valid/out_stall out_word_t: frame-end report
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a flat or surplus segment is dropped by the front; a frame end is pushed into the queue
// a steep segment holds the back through its load, the radix-4 division steps and the update
// a frame end is handled by the back once the output register is free
// synchronous active-low reset; no clearing pass, cfg_ready is always high
// the queue lets the front keep taking words while the back divides or the output is stalled, until it is full
module nearest_lane_line_selector_top import nlls_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_valid;
  job_t q_job_in, q_job_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_COLUMN:    cfg_nxt.center_column    = cfg_data;
        REG_SCAN_ROW:         cfg_nxt.scan_row         = cfg_data;
        REG_SEARCH_LIMIT:     cfg_nxt.search_limit     = cfg_data;
        REG_FAR_LEFT_LIMIT:   cfg_nxt.far_left_limit   = cfg_data;
        REG_NEAR_RIGHT_LIMIT: cfg_nxt.near_right_limit = cfg_data;
        REG_NEAR_LEFT_LIMIT:  cfg_nxt.near_left_limit  = cfg_data;
        REG_FAR_RIGHT_LIMIT:  cfg_nxt.far_right_limit  = cfg_data;
        REG_WARNING_HOLD:     cfg_nxt.warning_hold     = cfg_data[HOLD_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_column    <= CENTER_COLUMN_RST;
      cfg_r.scan_row         <= SCAN_ROW_RST;
      cfg_r.search_limit     <= SEARCH_LIMIT_RST;
      cfg_r.far_left_limit   <= FAR_LEFT_LIMIT_RST;
      cfg_r.near_right_limit <= NEAR_RIGHT_LIMIT_RST;
      cfg_r.near_left_limit  <= NEAR_LEFT_LIMIT_RST;
      cfg_r.far_right_limit  <= FAR_RIGHT_LIMIT_RST;
      cfg_r.warning_hold     <= WARNING_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nlls_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .scan_row (cfg_r.scan_row),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job_in)
  );

  nlls_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .job_out (q_job_out)
  );

  nlls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_job_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: dv/tb_nearest_lane_line_selector_top.sv
// testbench for nearest_lane_line_selector_top: directed and random frames against a lane predictor
`timescale 1ns / 100ps

module tb_nearest_lane_line_selector_top;
  import nlls_pkg::*;

  localparam int SEGMENT_SLOTS   = MAX_SEGMENTS_DEF;
  localparam int IDLE_PAUSE      = 120;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index = REG_CENTER_COLUMN;
  logic [CFG_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  bit hold_off_req  = 1'b0;
  int stall_run     = 0;
  int quiet_cycles  = 0;

  cfg_t               lane_cfg;
  logic [CFG_W-1:0]   best_left_dist;
  logic [CFG_W-1:0]   best_right_dist;
  logic [INDEX_W-1:0] best_left_seg;
  logic [INDEX_W-1:0] best_right_seg;
  int                 segments_taken;
  logic               left_seen;
  logic               right_seen;
  logic [HOLD_W-1:0]  hold_right_cnt;
  logic [HOLD_W-1:0]  hold_left_cnt;
  out_word_t          reports_due[$];

  nearest_lane_line_selector_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  task automatic start_frame();
    best_left_dist  = lane_cfg.search_limit;
    best_right_dist = lane_cfg.search_limit;
    best_left_seg   = '0;
    best_right_seg  = '0;
    segments_taken  = 0;
    left_seen       = 1'b0;
    right_seen      = 1'b0;
  endtask

  task automatic track_lane_word(in_word_t w);
    longint x1, y1, x2, y2, dx, dy, adx, ady, crossing, offset, bound;
    logic [INDEX_W-1:0] idx;
    int slope;
    out_word_t r;
    if (w.req_type == REQ_SEGMENT) begin
      if (segments_taken < SEGMENT_SLOTS) begin
        idx = INDEX_W'(segments_taken);
        segments_taken++;
        x1 = longint'(w.seg_x1);
        y1 = longint'(w.seg_y1);
        x2 = longint'(w.seg_x2);
        y2 = longint'(w.seg_y2);
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (5 * ady > 2 * adx) begin
          slope = (dx == 0) ? sign_of(dy) : sign_of(dx) * sign_of(dy);
          crossing = (x2 * dy + (longint'(lane_cfg.scan_row) - y2) * dx) / dy;
          offset = crossing - longint'(lane_cfg.center_column);
          if (offset > 0 && slope > 0) begin
            bound = longint'(best_right_dist);
            if (offset < bound) begin
              best_right_dist = CFG_W'(offset);
              best_right_seg  = idx;
              right_seen      = 1'b1;
            end
          end
          if (offset < 0 && slope < 0) begin
            bound = longint'(best_left_dist);
            if (-offset < bound) begin
              best_left_dist = CFG_W'(-offset);
              best_left_seg  = idx;
              left_seen      = 1'b1;
            end
          end
        end
      end
    end else begin
      if (left_seen && right_seen) begin
        if (best_left_dist > lane_cfg.far_left_limit &&
            best_right_dist < lane_cfg.near_right_limit) begin
          hold_right_cnt = lane_cfg.warning_hold;
        end
        if (best_left_dist < lane_cfg.near_left_limit &&
            best_right_dist > lane_cfg.far_right_limit) begin
          hold_left_cnt = lane_cfg.warning_hold;
        end
      end
      r.left_found        = left_seen;
      r.right_found       = right_seen;
      r.left_distance     = best_left_dist;
      r.right_distance    = best_right_dist;
      r.left_segment      = best_left_seg;
      r.right_segment     = best_right_seg;
      r.warn_change_right = (hold_right_cnt != 0);
      r.warn_change_left  = (hold_left_cnt != 0);
      reports_due = {reports_due, r};
      if (hold_right_cnt != 0) hold_right_cnt--;
      if (hold_left_cnt != 0) hold_left_cnt--;
      start_frame();
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [CFG_W-1:0] got, logic [CFG_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reports_due.size() == 0) begin
        report_mismatch("frame report with none pending");
      end else begin
        want = reports_due.pop_front();
        check_field("left_found", CFG_W'(out_word.left_found), CFG_W'(want.left_found));
        check_field("right_found", CFG_W'(out_word.right_found), CFG_W'(want.right_found));
        check_field("left_distance", out_word.left_distance, want.left_distance);
        check_field("right_distance", out_word.right_distance, want.right_distance);
        check_field("left_segment", CFG_W'(out_word.left_segment),
                    CFG_W'(want.left_segment));
        check_field("right_segment", CFG_W'(out_word.right_segment),
                    CFG_W'(want.right_segment));
        check_field("warn_change_right", CFG_W'(out_word.warn_change_right),
                    CFG_W'(want.warn_change_right));
        check_field("warn_change_left", CFG_W'(out_word.warn_change_left),
                    CFG_W'(want.warn_change_left));
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_run    = HOLD_OFF_CYCLES;
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("nearest_lane_line_selector_top: mismatch");
    $finish;
  end

  function automatic in_word_t seg_word(int x1, int y1, int x2, int y2);
    in_word_t w;
    w.req_type = REQ_SEGMENT;
    w.seg_x1   = COORD_BITS'(x1);
    w.seg_y1   = COORD_BITS'(y1);
    w.seg_x2   = COORD_BITS'(x2);
    w.seg_y2   = COORD_BITS'(y2);
    return w;
  endfunction

  function automatic in_word_t frame_end_word();
    in_word_t w;
    w = seg_word($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095));
    w.req_type = REQ_FRAME_END;
    return w;
  endfunction

  // vertical segment crossing the scan row at the given offset from centre
  function automatic in_word_t lane_word(int offset);
    int col, lo, hi;
    col = int'(lane_cfg.center_column) + offset;
    col = (col < 0) ? 0 : ((col > 4095) ? 4095 : col);
    lo  = $urandom_range(0, 2000);
    hi  = lo + $urandom_range(1, 2000);
    if (offset >= 0) return seg_word(col, lo, col, hi);
    return seg_word(col, hi, col, lo);
  endfunction

  function automatic in_word_t random_segment();
    in_word_t w;
    int pick, lim, mag, x, y;
    logic [COORD_BITS-1:0] swap;
    pick = $urandom_range(99);
    if (pick < 60) begin
      lim = int'(lane_cfg.search_limit);
      mag = $urandom_range(0, lim + lim / 4 + 2);
      w   = lane_word($urandom_range(1) ? mag : -mag);
      if ($urandom_range(99) < 30) begin
        x = int'(w.seg_x2) - int'($urandom_range(1, 40));
        w.seg_x1 = COORD_BITS'((x < 0) ? 0 : x);
      end
      if ($urandom_range(99) < 15) begin
        swap     = w.seg_y1;
        w.seg_y1 = w.seg_y2;
        w.seg_y2 = swap;
      end
    end else if (pick < 85) begin
      w = seg_word($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095));
    end else if (pick < 95) begin
      y = $urandom_range(4095);
      w = seg_word($urandom_range(4095), y, $urandom_range(4095), y);
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
      w = seg_word(x, y, x, y);
    end
    return w;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.center_column = CFG_W'($urandom_range(300, 3800));
    c.scan_row      = CFG_W'($urandom_range(0, 4095));
    c.search_limit  = CFG_W'(($urandom_range(3) == 0) ? $urandom_range(1, 4095)
                                                      : $urandom_range(20, 600));
    c.far_left_limit   = CFG_W'($urandom_range(0, c.search_limit));
    c.near_right_limit = CFG_W'($urandom_range(0, c.search_limit));
    c.near_left_limit  = CFG_W'($urandom_range(0, c.search_limit));
    c.far_right_limit  = CFG_W'($urandom_range(0, c.search_limit));
    c.warning_hold     = HOLD_W'(($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                          : $urandom_range(1, 4));
    return c;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_lane_word(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    wait_idle();
    write_reg(REG_CENTER_COLUMN, c.center_column);
    write_reg(REG_SCAN_ROW, c.scan_row);
    write_reg(REG_SEARCH_LIMIT, c.search_limit);
    write_reg(REG_FAR_LEFT_LIMIT, c.far_left_limit);
    write_reg(REG_NEAR_RIGHT_LIMIT, c.near_right_limit);
    write_reg(REG_NEAR_LEFT_LIMIT, c.near_left_limit);
    write_reg(REG_FAR_RIGHT_LIMIT, c.far_right_limit);
    write_reg(REG_WARNING_HOLD, {(CFG_W - HOLD_W)'($urandom), c.warning_hold});
    cfg_valid <= 1'b0;
    lane_cfg = c;
  endtask

  task automatic test_reset_report();
    in_word_t w;
    w = '1;
    send_word(w);
  endtask

  task automatic test_directed_frames();
    send_word(lane_word(40));
    send_word(lane_word(-200));
    send_word(lane_word(40));
    send_word(seg_word(0, 4095, 4095, 4095));
    send_word(seg_word(0, 0, 0, 0));
    send_word(seg_word(900, 0, 1000, 700));
    send_word(seg_word(20, 4000, 0, 3000));
    send_word(seg_word(0, 0, 4095, 4095));
    send_word(seg_word(1000, 100, 1005, 102));
    send_word(seg_word(1000, 100, 1007, 103));
    send_word(frame_end_word());
    send_word(lane_word(300));
    send_word(lane_word(-30));
    send_word(frame_end_word());
    send_word(frame_end_word());
  endtask

  task automatic test_segment_overflow();
    int row;
    for (int i = 0; i < SEGMENT_SLOTS - 1; i++) begin
      row = $urandom_range(4095);
      send_word(seg_word($urandom_range(4095), row, $urandom_range(4095), row));
    end
    send_word(lane_word(50));
    send_word(lane_word(10));
    send_word(lane_word(-5));
    send_word(frame_end_word());
    send_word(lane_word(-10));
    send_word(frame_end_word());
  endtask

  task automatic test_limit_mid_frame();
    cfg_t c;
    c = lane_cfg;
    c.search_limit = CFG_W'(100);
    send_word(lane_word(300));
    load_config(c);
    send_word(lane_word(-250));
    send_word(frame_end_word());
    send_word(lane_word(150));
    send_word(lane_word(-40));
    send_word(frame_end_word());
  endtask

  task automatic test_back_pressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_word(random_segment());
      else send_word(frame_end_word());
    end
  endtask

  task automatic run_random_frames(int n_items);
    int sent, pick, len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      len  = (pick < 10) ? 0 : ((pick < 80) ? $urandom_range(1, 8) : $urandom_range(9, 30));
      repeat (len) send_word(random_segment());
      send_word(frame_end_word());
      sent += len + 1;
    end
  endtask

  task automatic test_random_frames(int n_items, cfg_t opening);
    load_config(opening);
    run_random_frames(n_items / 3);
    load_config(random_config());
    run_random_frames(n_items / 3);
    load_config(random_config());
    run_random_frames(n_items / 3);
  endtask

  initial begin
    cfg_t low_corner, high_corner, warn_corner;
    low_corner  = '{12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0, 8'd1};
    high_corner = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                    12'd4095, 8'd255};
    warn_corner = '{12'd2048, 12'd2000, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0, 8'd255};
    lane_cfg = '{CENTER_COLUMN_RST, SCAN_ROW_RST, SEARCH_LIMIT_RST, FAR_LEFT_LIMIT_RST,
                 NEAR_RIGHT_LIMIT_RST, NEAR_LEFT_LIMIT_RST, FAR_RIGHT_LIMIT_RST,
                 WARNING_HOLD_RST};
    hold_right_cnt = '0;
    hold_left_cnt  = '0;
    start_frame();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 66;
    test_reset_report();
    test_directed_frames();
    test_segment_overflow();
    test_limit_mid_frame();
    test_random_frames(255, low_corner);

    send_idle_pct = 66;
    recv_idle_pct = 8;
    test_random_frames(255, high_corner);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_back_pressure();
    test_random_frames(255, warn_corner);

    wait_idle();
    if (mismatches == 0) begin
      $display("nearest_lane_line_selector_top: match");
    end else begin
      $display("nearest_lane_line_selector_top: mismatch");
    end
    $finish;
  end

endmodule
